/* design/jets_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Julia escape-time pixel unit.
// Used by jets_color and julia_escape_time_pixel_unit; depends on nothing else.
package jets_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 1024;
  localparam int FRAC_BITS    = 28;

  // Width of (2*pixel - size), which holds every image size up to 4096.
  localparam int COORD_W = 14;
  localparam int PIX_W   = 10;
  localparam int ITER_W  = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int SUM_W   = 66;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_C_REAL   = 3'd0;
  localparam logic [2:0] REG_C_IMAG   = 3'd1;
  localparam logic [2:0] REG_CTR_REAL = 3'd2;
  localparam logic [2:0] REG_CTR_IMAG = 3'd3;
  localparam logic [2:0] REG_STEP     = 3'd4;
  localparam logic [2:0] REG_LIMIT    = 3'd5;
  localparam logic [2:0] REG_MAX_ITER = 3'd6;

  localparam logic signed [31:0] C_REAL_RESET   = -32'sd214748365;
  localparam logic signed [31:0] C_IMAG_RESET   = 32'sd40265318;
  localparam logic signed [31:0] CTR_RESET      = 32'sd0;
  localparam logic [30:0]        STEP_RESET     = 31'd786432;
  localparam logic [31:0]        LIMIT_RESET    = 32'd411102190;
  localparam logic [15:0]        MAX_ITER_RESET = 16'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_X,
    S_START_Y,
    S_LOAD_Y,
    S_ITER_AA,
    S_ITER_BB,
    S_ITER_AB,
    S_ITER_UPD,
    S_COLOR,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_X,
    MUL_Y,
    MUL_AA,
    MUL_BB,
    MUL_AB
  } mul_op_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIV,
    C_MUL,
    C_QUO,
    C_SUM,
    C_DONE
  } color_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    load_pix;
    logic    set_a_start;
    logic    set_b_start;
    logic    cap_aa;
    logic    cap_bb;
    logic    step_z;
    logic    color_start;
    logic    load_out;
  } ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic rgb_t palette(input logic [2:0] idx);
    rgb_t p;
    case (idx)
      3'd0:    p = '{red: 8'd0,  green: 8'd0,   blue: 8'd0};
      3'd1:    p = '{red: 8'd14, green: 8'd35,  blue: 8'd187};
      3'd2:    p = '{red: 8'd79, green: 8'd14,  blue: 8'd187};
      3'd3:    p = '{red: 8'd14, green: 8'd122, blue: 8'd187};
      3'd4:    p = '{red: 8'd14, green: 8'd187, blue: 8'd166};
      3'd5:    p = '{red: 8'd9,  green: 8'd116, blue: 8'd103};
      default: p = '{red: 8'd0,  green: 8'd0,   blue: 8'd0};
    endcase
    return p;
  endfunction

endpackage

/* design/jets_color.sv */
`timescale 1ns / 1ps
// Palette blend for escaped pixels: scales the count over six palette entries and
// interpolates by the exact fraction, using small restoring dividers. Uses jets_pkg.
module jets_color (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [15:0]           iter,
  input  logic [15:0]           max_iter,
  output logic                  done,
  output jets_pkg::rgb_t        rgb
);
  import jets_pkg::*;

  color_state_t state, state_next;

  logic [18:0]     rem;
  logic [2:0]      idx;
  logic [2:0]      bit_pos;
  logic [2:0][7:0] base;
  logic [2:0]      neg;
  logic [2:0][23:0] num;
  logic [2:0][7:0] quo;

  logic [2:0][7:0] p0;
  logic [2:0][7:0] p1;
  logic [23:0]     div_sh;
  rgb_t            pal_lo;
  rgb_t            pal_hi;

  always_comb begin
    pal_lo = palette(idx);
    pal_hi = palette(idx + 3'd1);
    p0[0] = pal_lo.red;
    p0[1] = pal_lo.green;
    p0[2] = pal_lo.blue;
    p1[0] = pal_hi.red;
    p1[1] = pal_hi.green;
    p1[2] = pal_hi.blue;
    div_sh = 24'(max_iter) << bit_pos;
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: if (start) state_next = C_DIV;
      C_DIV:  if (rem < 19'(max_iter)) state_next = C_MUL;
      C_MUL:  state_next = C_QUO;
      C_QUO:  if (bit_pos == 3'd0) state_next = C_SUM;
      C_SUM:  state_next = C_DONE;
      C_DONE: state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    done = (state == C_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The fraction rem/max is below one, so each blended step fits in eight quotient bits.
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          rem <= 19'({iter, 2'b00}) + 19'(iter);
          idx <= 3'd0;
        end
      end
      C_DIV: begin
        if (rem >= 19'(max_iter)) begin
          rem <= rem - 19'(max_iter);
          idx <= idx + 3'd1;
        end
      end
      C_MUL: begin
        for (int ch = 0; ch < 3; ch++) begin
          base[ch] <= p0[ch];
          neg[ch]  <= (p1[ch] < p0[ch]);
          quo[ch]  <= 8'd0;
          if (p1[ch] < p0[ch]) begin
            num[ch] <= 24'(p0[ch] - p1[ch]) * 24'(rem[15:0]);
          end else begin
            num[ch] <= 24'(p1[ch] - p0[ch]) * 24'(rem[15:0]);
          end
        end
        bit_pos <= 3'd7;
      end
      C_QUO: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (num[ch] >= div_sh) begin
            num[ch]          <= num[ch] - div_sh;
            quo[ch][bit_pos] <= 1'b1;
          end
        end
        bit_pos <= bit_pos - 3'd1;
      end
      C_SUM: begin
        rgb.red   <= blend_sum(base[0], quo[0], neg[0]);
        rgb.green <= blend_sum(base[1], quo[1], neg[1]);
        rgb.blue  <= blend_sum(base[2], quo[2], neg[2]);
      end
      default: begin
      end
    endcase
  end

  function automatic logic [7:0] blend_sum(input logic [7:0] b, input logic [7:0] q,
                                           input logic n);
    logic signed [9:0] v;
    logic [7:0]        r;
    v = n ? (signed'(10'(b)) - signed'(10'(q))) : (signed'(10'(b)) + signed'(10'(q)));
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endmodule

/* design/julia_escape_time_pixel_unit.sv */
`timescale 1ns / 1ps
// Top level of the Julia escape-time pixel unit: configuration registers, sequencer,
// shared 32x32 multiplier and output register. Uses jets_pkg and jets_color.
//
// A pixel (pixel_x, pixel_y) is a transfer on the input channel when in_valid is high
// and in_stall is low. The unit maps it to a start point, iterates z = z*z + c and
// returns one result: iteration count, escaped flag and a blended palette color. The
// user must write configuration over the APB port while no pixel is in flight (unchecked).
//
// One pixel is worked on at a time, and in_stall is high while it is in flight. The
// single signed 32x32 multiplier sets the pace: states S_START_X, S_START_Y and S_LOAD_Y
// form the start point, then each iteration takes three products and an update. An
// escaped pixel adds a color blend (a divide by the iteration cap done in steps).
//
// Results sit in an output register. While out_stall holds a result, the next pixel
// is still taken and iterated, and it waits at the end until the register is free.
// Reset clears the sequencer and the output valid and loads the register defaults.
module julia_escape_time_pixel_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jets_pkg::PIX_W-1:0]    pixel_x,
  input  logic [jets_pkg::PIX_W-1:0]    pixel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jets_pkg::ITER_W-1:0]   iteration_count,
  output logic                          escaped,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jets_pkg::ADDR_W-1:0]   paddr,
  input  logic [jets_pkg::DATA_W-1:0]   pwdata,
  output logic [jets_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import jets_pkg::*;

  // Configuration registers.
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;
  logic signed [31:0] center_real;
  logic signed [31:0] center_imag;
  logic [30:0]        pixel_step;
  logic [31:0]        escape_limit;
  logic [15:0]        max_iterations;

  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real         <= C_REAL_RESET;
      c_imag         <= C_IMAG_RESET;
      center_real    <= CTR_RESET;
      center_imag    <= CTR_RESET;
      pixel_step     <= STEP_RESET;
      escape_limit   <= LIMIT_RESET;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_C_REAL:   c_real         <= signed'(pwdata);
        REG_C_IMAG:   c_imag         <= signed'(pwdata);
        REG_CTR_REAL: center_real    <= signed'(pwdata);
        REG_CTR_IMAG: center_imag    <= signed'(pwdata);
        REG_STEP:     pixel_step     <= pwdata[30:0];
        REG_LIMIT:    escape_limit   <= pwdata;
        REG_MAX_ITER: max_iterations <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_C_REAL:   prdata = unsigned'(c_real);
      REG_C_IMAG:   prdata = unsigned'(c_imag);
      REG_CTR_REAL: prdata = unsigned'(center_real);
      REG_CTR_IMAG: prdata = unsigned'(center_imag);
      REG_STEP:     prdata = 32'(pixel_step);
      REG_LIMIT:    prdata = escape_limit;
      REG_MAX_ITER: prdata = 32'(max_iterations);
      default:      prdata = '0;
    endcase
  end

  // Sequencer and datapath registers.
  state_t state, state_next;
  ctrl_t  ctrl;

  logic [PIX_W-1:0]   px;
  logic [PIX_W-1:0]   py;
  logic signed [31:0] za;
  logic signed [31:0] zb;
  logic [ITER_W-1:0]  iter;
  logic signed [63:0] aa;
  logic signed [63:0] bb;
  logic signed [63:0] prod;
  logic               esc;

  logic signed [COORD_W-1:0] dx;
  logic signed [COORD_W-1:0] dy;
  logic signed [31:0]        mul_a;
  logic signed [31:0]        mul_b;
  logic signed [63:0]        mul_p;
  logic [63:0]               mag;
  logic                      escape_hit;
  logic                      out_free;
  logic                      color_done;
  rgb_t                      color_rgb;

  assign dx = signed'(COORD_W'({px, 1'b0})) - signed'(COORD_W'(IMAGE_WIDTH));
  assign dy = signed'(COORD_W'({py, 1'b0})) - signed'(COORD_W'(IMAGE_HEIGHT));

  always_comb begin
    case (ctrl.mul_op)
      MUL_X: begin
        mul_a = 32'(dx);
        mul_b = signed'({1'b0, pixel_step});
      end
      MUL_Y: begin
        mul_a = 32'(dy);
        mul_b = signed'({1'b0, pixel_step});
      end
      MUL_AA: begin
        mul_a = za;
        mul_b = za;
      end
      MUL_BB: begin
        mul_a = zb;
        mul_b = zb;
      end
      MUL_AB: begin
        mul_a = za;
        mul_b = zb;
      end
      default: begin
        mul_a = za;
        mul_b = zb;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // In the cycle of the cross product, aa holds a*a and prod holds b*b.
  assign mag        = unsigned'(aa) + unsigned'(prod);
  assign escape_hit = (mag >> FRAC_BITS) >= 64'(escape_limit);
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_START_X;
      S_START_X:  state_next = S_START_Y;
      S_START_Y:  state_next = S_LOAD_Y;
      S_LOAD_Y:   state_next = S_ITER_AA;
      S_ITER_AA:  state_next = (iter >= max_iterations) ? S_DONE : S_ITER_BB;
      S_ITER_BB:  state_next = S_ITER_AB;
      S_ITER_AB:  state_next = escape_hit ? S_COLOR : S_ITER_UPD;
      S_ITER_UPD: state_next = S_ITER_AA;
      S_COLOR:    if (color_done) state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl             = '0;
    ctrl.mul_op      = MUL_AB;
    case (state)
      S_IDLE:     ctrl.load_pix = in_valid;
      S_START_X:  ctrl.mul_op = MUL_X;
      S_START_Y: begin
        ctrl.mul_op      = MUL_Y;
        ctrl.set_a_start = 1'b1;
      end
      S_LOAD_Y:   ctrl.set_b_start = 1'b1;
      S_ITER_AA:  ctrl.mul_op = MUL_AA;
      S_ITER_BB: begin
        ctrl.mul_op = MUL_BB;
        ctrl.cap_aa = 1'b1;
      end
      S_ITER_AB: begin
        ctrl.mul_op      = MUL_AB;
        ctrl.cap_bb      = 1'b1;
        ctrl.color_start = escape_hit;
      end
      S_ITER_UPD: ctrl.step_z = 1'b1;
      S_DONE:     ctrl.load_out = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (ctrl.load_pix) begin
      px   <= pixel_x;
      py   <= pixel_y;
      iter <= '0;
      esc  <= 1'b0;
    end
    if (ctrl.set_a_start) begin
      za <= sat32(SUM_W'(center_real) + SUM_W'(prod >>> 1));
    end
    if (ctrl.set_b_start) begin
      zb <= sat32(SUM_W'(center_imag) + SUM_W'(prod >>> 1));
    end
    if (ctrl.cap_aa) begin
      aa <= prod;
    end
    if (ctrl.cap_bb) begin
      bb <= prod;
    end
    if (ctrl.color_start) begin
      esc <= 1'b1;
    end
    if (ctrl.step_z) begin
      za   <= sat32(SUM_W'((aa - bb) >>> FRAC_BITS) + SUM_W'(c_real));
      zb   <= sat32(SUM_W'(prod >>> (FRAC_BITS - 1)) + SUM_W'(c_imag));
      iter <= iter + 16'd1;
    end
  end

  jets_color u_color (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.color_start),
    .iter     (iter),
    .max_iter (max_iterations),
    .done     (color_done),
    .rgb      (color_rgb)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      iteration_count <= iter;
      escaped         <= esc;
      red             <= esc ? color_rgb.red   : 8'd0;
      green           <= esc ? color_rgb.green : 8'd0;
      blue            <= esc ? color_rgb.blue  : 8'd0;
    end
  end

  a_black_when_captive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !escaped) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("non-escaped pixel carries a color");

  a_escape_below_cap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && escaped) |-> (iteration_count < max_iterations))
    else $error("escaped pixel reports a count at or above the cap");

  a_count_within_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (iteration_count <= max_iterations))
    else $error("iteration count exceeds the cap");

  a_color_done_in_phase: assert property (@(posedge clk) disable iff (rst)
    color_done |-> (state == S_COLOR))
    else $error("color blend finished outside the color phase");

endmodule
